// ===== hw/rtl/handshake_to_fpga_config_bridge_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the handshake to FPGA configuration bridge
// Shared forms for the concurrent checks on the bridge ports.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_TO_FPGA_CONFIG_BRIDGE_ASSERT_SVH
`define HANDSHAKE_TO_FPGA_CONFIG_BRIDGE_ASSERT_SVH

// check held outside reset
`define HSCFG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// check that also covers the reset cycles
`define HSCFG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hw/rtl/hscfg_pkg.sv =====
// ----------------------------------------------------------------------------
// hscfg_pkg
// Types and link codes shared by the bridge modules.
// ----------------------------------------------------------------------------
package hscfg_pkg;

   // codes seen on and driven to the partner link
   localparam logic [2:0] CODE_READY = 3'h3;
   localparam logic [2:0] CODE_PUT   = 3'h4;
   localparam logic [2:0] CODE_ACK0  = 3'h5;
   localparam logic [2:0] CODE_ACK1  = 3'h2;
   localparam logic [2:0] CODE_DONE  = 3'h6;

   // trailing clock register reset value
   localparam logic [7:0] TRAILING_RESET = 8'd64;

   typedef enum logic [1:0] {
      PH_WAIT_READY = 2'd0,
      PH_WAIT_PUT   = 2'd1,
      PH_RECEIVE    = 2'd2,
      PH_ENDED      = 2'd3
   } phase_type;

   // transfer state carried from beat to beat
   typedef struct packed {
      phase_type  phase;
      logic       expected_tag;
      logic       done_seen;
      logic [2:0] link_out;
   } state_type;

   // one input beat
   typedef struct packed {
      logic       link_tag;
      logic [2:0] link_code;
      logic [7:0] link_data;
      logic       done_level;
   } poll_type;

   // one result beat
   typedef struct packed {
      logic [2:0] link_out;
      logic       cfg_valid;
      logic [7:0] cfg_byte;
      logic [7:0] extra_clock_count;
      logic [1:0] transfer_phase;
   } result_type;

endpackage

// ===== hw/rtl/handshake_to_fpga_config_bridge.sv =====
// A poll accepted at a clock edge shows its result beat from the next cycle.
// Throughput: one poll per cycle while the result side is ready; the result register refills while being taken.
// Rate is set by the single result register between the step logic and rsp_.
// Reset (synchronous, active high): phase wait-ready, tag 0, link code ready,
// trailing clocks 64, result register empty.
// ----------------------------------------------------------------------------
// handshake_to_fpga_config_bridge
// Tagged byte link to FPGA configuration port bridge, one poll per beat.
// ----------------------------------------------------------------------------
module handshake_to_fpga_config_bridge (
   input  logic       clock,
   input  logic       reset,
   // poll channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_link_tag,
   input  logic [2:0] req_link_code,
   input  logic [7:0] req_link_data,
   input  logic       req_done_level,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_link_out,
   output logic       rsp_cfg_valid,
   output logic [7:0] rsp_cfg_byte,
   output logic [7:0] rsp_extra_clock_count,
   output logic [1:0] rsp_transfer_phase,
   // trailing clocks register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   hscfg_pkg::state_type  state_ff;
   hscfg_pkg::state_type  state_in;
   hscfg_pkg::result_type result_ff;
   hscfg_pkg::result_type result_in;
   hscfg_pkg::poll_type   poll;
   logic                  rsp_valid_ff;
   logic [7:0]            trailing_ff;
   logic                  accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign poll      = '{link_tag:   req_link_tag,
                        link_code:  req_link_code,
                        link_data:  req_link_data,
                        done_level: req_done_level};

   hscfg_step u_step (
      .state_cur       (state_ff),
      .poll            (poll),
      .trailing_clocks (trailing_ff),
      .state_nxt       (state_in),
      .result          (result_in)
   );

   // trailing clock count register
   always_ff @(posedge clock) begin
      if (reset) begin
         trailing_ff <= hscfg_pkg::TRAILING_RESET;
      end else if (csr_wr_en) begin
         trailing_ff <= csr_wr_data;
      end
   end

   // transfer state, advanced per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= hscfg_pkg::PH_WAIT_READY;
         state_ff.expected_tag <= 1'b0;
         state_ff.done_seen    <= 1'b0;
         state_ff.link_out     <= hscfg_pkg::CODE_READY;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_link_out          = result_ff.link_out;
   assign rsp_cfg_valid         = result_ff.cfg_valid;
   assign rsp_cfg_byte          = result_ff.cfg_byte;
   assign rsp_extra_clock_count = result_ff.extra_clock_count;
   assign rsp_transfer_phase    = result_ff.transfer_phase;

endmodule

// ===== hw/rtl/hscfg_step.sv =====
// ----------------------------------------------------------------------------
// hscfg_step
// Next-state and result logic for one link poll.
// ----------------------------------------------------------------------------
module hscfg_step (
   input  hscfg_pkg::state_type  state_cur,
   input  hscfg_pkg::poll_type   poll,
   input  logic [7:0]            trailing_clocks,
   output hscfg_pkg::state_type  state_nxt,
   output hscfg_pkg::result_type result
);

   hscfg_pkg::phase_type phase_mid;
   logic                 tag_mid;
   logic [7:0]           data_rev;

   // configuration pins take the byte LSB first
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         data_rev[i] = poll.link_data[7 - i];
      end
   end

   // start-up handshake: ready, then put (tag ignored here)
   always_comb begin
      phase_mid = state_cur.phase;
      tag_mid   = state_cur.expected_tag;
      case (state_cur.phase)
         hscfg_pkg::PH_WAIT_READY: begin
            if (poll.link_code == hscfg_pkg::CODE_READY) phase_mid = hscfg_pkg::PH_WAIT_PUT;
         end
         hscfg_pkg::PH_WAIT_PUT: begin
            if (poll.link_code == hscfg_pkg::CODE_PUT) begin
               phase_mid = hscfg_pkg::PH_RECEIVE;
               tag_mid   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // receive phase; the opening put is also the first received byte
   always_comb begin
      state_nxt              = state_cur;
      state_nxt.phase        = phase_mid;
      state_nxt.expected_tag = tag_mid;
      result                 = '0;
      if (phase_mid == hscfg_pkg::PH_RECEIVE && poll.link_tag == tag_mid) begin
         if (poll.link_code == hscfg_pkg::CODE_PUT) begin
            state_nxt.link_out     = tag_mid ? hscfg_pkg::CODE_ACK1 : hscfg_pkg::CODE_ACK0;
            state_nxt.expected_tag = ~tag_mid;
            result.cfg_valid       = 1'b1;
            result.cfg_byte        = data_rev;
            // first DONE after a clocked byte closes the transfer
            if (poll.done_level && !state_cur.done_seen) begin
               state_nxt.done_seen    = 1'b1;
               state_nxt.link_out     = hscfg_pkg::CODE_DONE;
               state_nxt.phase        = hscfg_pkg::PH_ENDED;
               result.extra_clock_count = trailing_clocks;
            end
         end else begin
            state_nxt.phase = hscfg_pkg::PH_ENDED;
         end
      end
      result.link_out       = state_nxt.link_out;
      result.transfer_phase = state_nxt.phase;
   end

endmodule

// ===== hw/rtl/hscfg_checker.sv =====
// ----------------------------------------------------------------------------
// hscfg_checker
// Port-level checks on the bridge, bound to the top level.
// ----------------------------------------------------------------------------
`include "handshake_to_fpga_config_bridge_assert.svh"

module hscfg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_link_out,
   input logic       rsp_cfg_valid,
   input logic [7:0] rsp_cfg_byte,
   input logic [7:0] rsp_extra_clock_count,
   input logic [1:0] rsp_transfer_phase
);

   // a waiting result beat is not dropped
   `HSCFG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")

   // result register is empty straight after reset
   `HSCFG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // no byte clocked means the data pins read zero
   `HSCFG_ASSERT(a_byte_quiet, clock, reset, rsp_valid && !rsp_cfg_valid |-> rsp_cfg_byte == 8'h00, "cfg byte without valid")

   // trailing clocks only come with the done code and the ended phase
   `HSCFG_ASSERT(a_extra_done, clock, reset, rsp_valid && rsp_extra_clock_count != 8'h00 |-> rsp_link_out == hscfg_pkg::CODE_DONE && rsp_transfer_phase == hscfg_pkg::PH_ENDED && rsp_cfg_valid, "trailing clocks outside done")

   // a clocked byte is acknowledged or closes the transfer
   `HSCFG_ASSERT(a_byte_ack, clock, reset, rsp_valid && rsp_cfg_valid |-> rsp_link_out == hscfg_pkg::CODE_ACK0 || rsp_link_out == hscfg_pkg::CODE_ACK1 || rsp_link_out == hscfg_pkg::CODE_DONE, "byte without ack")

endmodule

bind handshake_to_fpga_config_bridge hscfg_checker u_hscfg_checker (.*);

// ===== tb/sv/tb_hscfg_result_checker.sv =====
// ----------------------------------------------------------------------------
// tb_hscfg_result_checker
// Watches the poll and result channels of the link-to-configuration bridge,
// works out the result beat for every accepted poll and compares each result
// beat, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tb_hscfg_result_checker (
   input  logic       clock,
   input  logic       reset,
   // poll channel
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_link_tag,
   input  logic [2:0] req_link_code,
   input  logic [7:0] req_link_data,
   input  logic       req_done_level,
   // result channel
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_link_out,
   input  logic       rsp_cfg_valid,
   input  logic [7:0] rsp_cfg_byte,
   input  logic [7:0] rsp_extra_clock_count,
   input  logic [1:0] rsp_transfer_phase,
   // trailing clocks register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   // to the testbench top
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the bridge state
   hscfg_pkg::phase_type link_phase;
   logic                 want_tag;
   logic                 done_flag;
   logic [2:0]           partner_code;
   logic [7:0]           trailing_clocks;

   hscfg_pkg::result_type outstanding_results[$];
   int                    errors = 0;

   // one poll of the link: advance the shadow state, return the result beat
   function automatic hscfg_pkg::result_type step_link(input hscfg_pkg::poll_type poll);
      hscfg_pkg::result_type res;
      int                    i;
      res = '0;
      // opening handshake, tag not looked at
      case (link_phase)
         hscfg_pkg::PH_WAIT_READY: begin
            if (poll.link_code == hscfg_pkg::CODE_READY)
               link_phase = hscfg_pkg::PH_WAIT_PUT;
         end
         hscfg_pkg::PH_WAIT_PUT: begin
            if (poll.link_code == hscfg_pkg::CODE_PUT) begin
               link_phase = hscfg_pkg::PH_RECEIVE;
               want_tag   = 1'b0;
            end
         end
         default: ;
      endcase
      // the opening put falls through to here as the first receive poll
      if (link_phase == hscfg_pkg::PH_RECEIVE && poll.link_tag == want_tag) begin
         if (poll.link_code == hscfg_pkg::CODE_PUT) begin
            partner_code  = want_tag ? hscfg_pkg::CODE_ACK1 : hscfg_pkg::CODE_ACK0;
            want_tag      = ~want_tag;
            res.cfg_valid = 1'b1;
            for (i = 0; i < 8; i++)
               res.cfg_byte[i] = poll.link_data[7 - i];
            // DONE only counts once a byte has been clocked
            if (poll.done_level && !done_flag) begin
               done_flag             = 1'b1;
               partner_code          = hscfg_pkg::CODE_DONE;
               res.extra_clock_count = trailing_clocks;
               link_phase            = hscfg_pkg::PH_ENDED;
            end
         end else begin
            link_phase = hscfg_pkg::PH_ENDED;
         end
      end
      res.link_out       = partner_code;
      res.transfer_phase = link_phase;
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // result beats are checked before the poll of the same edge is added;
   // a register write at this edge only applies to later polls
   always @(posedge clock) begin
      hscfg_pkg::poll_type   poll;
      hscfg_pkg::result_type want;
      if (reset) begin
         link_phase      = hscfg_pkg::PH_WAIT_READY;
         want_tag        = 1'b0;
         done_flag       = 1'b0;
         partner_code    = hscfg_pkg::CODE_READY;
         trailing_clocks = hscfg_pkg::TRAILING_RESET;
         outstanding_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outstanding_results.size() == 0) begin
               $display("%0t: result beat with none expected, actual link_out %0d phase %0d",
                        $time, rsp_link_out, rsp_transfer_phase);
               errors++;
            end else begin
               want = outstanding_results.pop_front();
               check_field("link_out", want.link_out, rsp_link_out);
               check_field("cfg_valid", want.cfg_valid, rsp_cfg_valid);
               check_field("cfg_byte", want.cfg_byte, rsp_cfg_byte);
               check_field("extra_clock_count", want.extra_clock_count,
                           rsp_extra_clock_count);
               check_field("transfer_phase", want.transfer_phase, rsp_transfer_phase);
            end
         end
         if (req_valid && req_ready) begin
            poll.link_tag   = req_link_tag;
            poll.link_code  = req_link_code;
            poll.link_data  = req_link_data;
            poll.done_level = req_done_level;
            outstanding_results.push_back(step_link(poll));
         end
         if (csr_wr_en)
            trailing_clocks = csr_wr_data;
      end
      fail_count <= errors;
      pending    <= outstanding_results.size();
   end

endmodule

// ===== tb/sv/tb_handshake_to_fpga_config_bridge.sv =====
// ----------------------------------------------------------------------------
// tb_handshake_to_fpga_config_bridge
// Drives link polls into the bridge: a directed opening handshake and receive
// sequence, then a long tagged byte stream with wrong-tag noise, then the end of
// transfer. Both channels stall at random bar a steady stretch; checker compares.
// ----------------------------------------------------------------------------
module tb_handshake_to_fpga_config_bridge;
   timeunit 1ns;
   timeprecision 1ps;

   // partner codes with no name in the package
   localparam logic [2:0] CODE_EOF      = 3'h1;
   localparam logic [2:0] CODE_OTHER_LO = 3'h0;
   localparam logic [2:0] CODE_OTHER_HI = 3'h7;

   localparam int unsigned BYTES_TOTAL    = 1100;
   localparam int unsigned STEADY_FIRST   = 500;
   localparam int unsigned STEADY_LAST    = 800;
   localparam int          WATCHDOG_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_link_tag;
   logic [2:0] req_link_code;
   logic [7:0] req_link_data;
   logic       req_done_level;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_link_out;
   logic       rsp_cfg_valid;
   logic [7:0] rsp_cfg_byte;
   logic [7:0] rsp_extra_clock_count;
   logic [1:0] rsp_transfer_phase;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   int         fail_count;
   int         pending;
   logic       steady;
   logic       next_tag;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   handshake_to_fpga_config_bridge dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_link_tag          (req_link_tag),
      .req_link_code         (req_link_code),
      .req_link_data         (req_link_data),
      .req_done_level        (req_done_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_link_out          (rsp_link_out),
      .rsp_cfg_valid         (rsp_cfg_valid),
      .rsp_cfg_byte          (rsp_cfg_byte),
      .rsp_extra_clock_count (rsp_extra_clock_count),
      .rsp_transfer_phase    (rsp_transfer_phase),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   tb_hscfg_result_checker results_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_link_tag          (req_link_tag),
      .req_link_code         (req_link_code),
      .req_link_data         (req_link_data),
      .req_done_level        (req_done_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_link_out          (rsp_link_out),
      .rsp_cfg_valid         (rsp_cfg_valid),
      .rsp_cfg_byte          (rsp_cfg_byte),
      .rsp_extra_clock_count (rsp_extra_clock_count),
      .rsp_transfer_phase    (rsp_transfer_phase),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   // result side back-pressure, off during the steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 8);
   end

   // one poll beat; valid stays up between back-to-back beats
   task automatic send_poll(input logic tag, input logic [2:0] code,
                            input logic [7:0] data, input logic done);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid      <= 1'b0;
         req_link_tag   <= 1'($urandom_range(1));
         req_link_code  <= 3'($urandom_range(7));
         req_link_data  <= 8'($urandom);
         req_done_level <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_link_tag   <= tag;
      req_link_code  <= code;
      req_link_data  <= data;
      req_done_level <= done;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // well-formed receive beat: put with the tag the bridge is waiting for
   task automatic put_byte(input logic [7:0] data);
      send_poll(next_tag, hscfg_pkg::CODE_PUT, data, 1'b0);
      next_tag = ~next_tag;
   endtask

   // wrong tag: any code, data and DONE level, to be ignored
   task automatic noise_poll();
      send_poll(~next_tag, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
   endtask

   // register write once every result beat is back
   task automatic write_trailing(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // watchdog: cycles with no beat on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned byte_count;
      logic        open_tag;
      logic [2:0]  end_code;
      logic [7:0]  last_trailing;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_link_tag   = 1'b0;
      req_link_code  = CODE_OTHER_LO;
      req_link_data  = 8'h00;
      req_done_level = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 8'h00;
      steady         = 1'b0;
      next_tag       = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // waiting for ready: only the code matters, DONE without a byte ignored
      send_poll(1'b1, hscfg_pkg::CODE_PUT, 8'hff, 1'b1);
      send_poll(1'b0, CODE_OTHER_LO, 8'h00, 1'b0);
      send_poll(1'b1, CODE_OTHER_HI, 8'ha5, 1'b1);
      send_poll(1'b1, hscfg_pkg::CODE_READY, 8'h00, 1'b0);
      // waiting for put
      send_poll(1'b0, hscfg_pkg::CODE_READY, 8'h3c, 1'b0);
      send_poll(1'b0, CODE_EOF, 8'hff, 1'b1);
      send_poll(1'b1, CODE_OTHER_HI, 8'h81, 1'b0);
      send_poll(1'b1, CODE_OTHER_LO, 8'h00, 1'b1);
      // opening put doubles as the first receive poll, expected tag 0
      open_tag = 1'($urandom_range(1));
      send_poll(open_tag, hscfg_pkg::CODE_PUT, 8'h01, 1'b0);
      next_tag = ~open_tag;
      // receiving: byte extremes and wrong-tag polls of every kind
      put_byte(8'h00);
      put_byte(8'hff);
      send_poll(~next_tag, CODE_EOF, 8'h12, 1'b1);
      send_poll(~next_tag, CODE_OTHER_LO, 8'h00, 1'b0);
      send_poll(~next_tag, hscfg_pkg::CODE_PUT, 8'h5a, 1'b1);
      put_byte(8'h80);
      put_byte(8'hc3);
      send_poll(~next_tag, hscfg_pkg::CODE_READY, 8'hff, 1'b0);
      send_poll(~next_tag, CODE_OTHER_HI, 8'h7e, 1'b1);
      write_trailing(8'd0);

      // long tagged stream with some noise and register changes on the way
      byte_count = 0;
      while (byte_count < BYTES_TOTAL) begin
         steady = (byte_count >= STEADY_FIRST) && (byte_count < STEADY_LAST);
         if ($urandom_range(99) < 80) begin
            put_byte(8'($urandom));
            byte_count++;
            if (byte_count == 350) begin
               write_trailing(8'd255);
            end else if (byte_count == 700) begin
               write_trailing(8'($urandom_range(1, 254)));
            end else if (byte_count == 1050) begin
               case ($urandom_range(2))
                  0:       last_trailing = 8'd0;
                  1:       last_trailing = 8'd255;
                  default: last_trailing = 8'($urandom_range(1, 254));
               endcase
               write_trailing(last_trailing);
            end
         end else begin
            noise_poll();
         end
      end
      steady = 1'b0;

      // end of transfer: DONE after a byte, or any other code with the right tag
      if ($urandom_range(1)) begin
         send_poll(next_tag, hscfg_pkg::CODE_PUT, 8'($urandom), 1'b1);
      end else begin
         end_code = 3'($urandom_range(6));
         if (end_code >= hscfg_pkg::CODE_PUT)
            end_code = end_code + 3'd1;
         send_poll(next_tag, end_code, 8'($urandom), 1'($urandom_range(1)));
      end
      // ended: everything is ignored from here on
      repeat (40)
         send_poll(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
                   1'($urandom_range(1)));

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
